// ----- hw/rtl/akpvt_pkg.sv -----
// package for the analog key press velocity tracker
// phase codes, register indexes, per-key state record and field widths
// no dependencies
`timescale 1ns / 1ps

package akpvt_pkg;

	// field widths
	localparam int KEY_W    = 4;
	localparam int TRAVEL_W = 13;
	localparam int SPEED_W  = 16;
	localparam int PHASE_W  = 3;
	localparam int FORCE_W  = 8;
	localparam int SCALE_W  = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 24;

	// key phases
	localparam logic [PHASE_W-1:0] PH_UP        = 3'd0;
	localparam logic [PHASE_W-1:0] PH_UP_CONF   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_FALL      = 3'd2;
	localparam logic [PHASE_W-1:0] PH_FALL_CONF = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DOWN      = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DOWN_CONF = 3'd5;
	localparam logic [PHASE_W-1:0] PH_RISE      = 3'd6;
	localparam logic [PHASE_W-1:0] PH_RISE_CONF = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REL_LEVEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRS_LEVEL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEILING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE   = 3'd4;

	// register reset values
	localparam logic [TRAVEL_W-1:0] REL_LEVEL_RST     = 13'd3277;
	localparam logic [TRAVEL_W-1:0] PRS_LEVEL_RST     = 13'd819;
	localparam logic [SPEED_W-1:0]  SPEED_FLOOR_RST   = 16'd0;
	localparam logic [SPEED_W-1:0]  SPEED_CEILING_RST = 16'hFFFF;
	localparam logic [SCALE_W-1:0]  FORCE_SCALE_RST   = 24'd255;

	localparam logic [FORCE_W-1:0] FORCE_MAX = 8'hFF;

	// per-key state word kept in the state memory
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [SPEED_W-1:0] peak;
		logic               pressed;
		logic [FORCE_W-1:0] force_lvl;
	} key_rec_t;

	localparam int STATE_W = $bits(key_rec_t);

endpackage

// ----- hw/rtl/akpvt_ram.sv -----
// generic single-write, single-read memory with registered read data
// used for the per-key state store; no dependencies
`timescale 1ns / 1ps

module akpvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/analog_key_press_velocity_tracker.sv -----
// analog key press velocity tracker, top level
// depends on akpvt_pkg and akpvt_ram
`timescale 1ns / 1ps

// Usage
// Input stream (s_*): one transaction per key sample, tdata holds the key id,
// travel and speed. Output stream (m_*): one transaction per sample with the
// key's new phase, pressed bit, press and release events and latched force.
// Configuration: cfg_we writes cfg_wdata into register cfg_index. The user must
// write only while no sample is in flight; the block does not enforce this.
// Data path: a taken sample is held in the update stage registers, and its result
// is then registered into the result register that drives the m_* port.
// Throughput: one sample per cycle while the output is not stalled. The per-key
// state sits in a memory with registered read; the read is issued when a sample
// is taken and the updated state is written back when it leaves the update
// stage, with the last write forwarded when the next sample hits the same key.
// Reset: all keys go to the up phase with zero peak, pressed bit and force
// (per-key valid flags make unwritten entries read as zero), and registers
// take their default values. No clearing pass is needed.
// Stall: while a result waits and m_tready is low the result register holds; one
// more sample may sit in the update stage, after which s_tready drops.

module analog_key_press_velocity_tracker
	import akpvt_pkg::*;
#(
	parameter int KEY_COUNT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // key_id[3:0], travel[16:4], speed[32:17], zero pad
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // key_number[3:0], phase[6:4], pressed[7],
	                                        // press_event[8], release_event[9], force_res[17:10]
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W + 1)'(KEY_COUNT);

	// configuration registers
	logic [TRAVEL_W-1:0] rel_level_q, prs_level_q;
	logic [SPEED_W-1:0]  speed_floor_q, speed_ceiling_q;
	logic [SCALE_W-1:0]  force_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_level_q     <= REL_LEVEL_RST;
			prs_level_q     <= PRS_LEVEL_RST;
			speed_floor_q   <= SPEED_FLOOR_RST;
			speed_ceiling_q <= SPEED_CEILING_RST;
			force_scale_q   <= FORCE_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REL_LEVEL:     rel_level_q     <= cfg_wdata[TRAVEL_W-1:0];
				CFG_PRS_LEVEL:     prs_level_q     <= cfg_wdata[TRAVEL_W-1:0];
				CFG_SPEED_FLOOR:   speed_floor_q   <= cfg_wdata[SPEED_W-1:0];
				CFG_SPEED_CEILING: speed_ceiling_q <= cfg_wdata[SPEED_W-1:0];
				CFG_FORCE_SCALE:   force_scale_q   <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [KEY_W-1:0]    in_key;
	logic [TRAVEL_W-1:0] in_travel;
	logic [SPEED_W-1:0]  in_speed;
	logic                in_range;
	logic                s_accept;

	assign in_key    = s_tdata[KEY_W-1:0];
	assign in_travel = s_tdata[KEY_W +: TRAVEL_W];
	assign in_speed  = s_tdata[KEY_W+TRAVEL_W +: SPEED_W];
	assign in_range  = {1'b0, in_key} < KEY_LIMIT;

	// pipeline control
	logic valid_s1, out_valid_q, adv_s1;
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_accept = s_tvalid && s_tready;

	// update stage registers
	logic [KEY_W-1:0]    key_s1;
	logic [TRAVEL_W-1:0] travel_s1;
	logic [SPEED_W-1:0]  speed_s1;
	logic                range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			key_s1    <= in_key;
			travel_s1 <= in_travel;
			speed_s1  <= in_speed;
			range_s1  <= in_range;
		end
	end

	// state memory
	key_rec_t rd_state, nxt_state;
	logic     wr_en;

	assign wr_en = adv_s1 && range_s1;

	akpvt_ram #(
		.WIDTH(STATE_W),
		.DEPTH(KEY_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (key_s1[AW-1:0]),
		.wdata (nxt_state),
		.re    (s_accept && in_range),
		.raddr (in_key[AW-1:0]),
		.rdata (rd_state)
	);

	// per-key written flags, an unwritten key reads as the reset state
	logic [KEY_COUNT-1:0] written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[key_s1[AW-1:0]] <= 1'b1;
		end
	end

	// last write, forwarded when the read raced it
	logic             fwd_valid_q;
	logic [AW-1:0]    fwd_key_q;
	key_rec_t         fwd_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_key_q   <= key_s1[AW-1:0];
			fwd_state_q <= nxt_state;
		end
	end

	key_rec_t cur_state;

	always_comb begin
		if (fwd_valid_q && fwd_key_q == key_s1[AW-1:0]) begin
			cur_state = fwd_state_q;
		end else if (written_q[key_s1[AW-1:0]]) begin
			cur_state = rd_state;
		end else begin
			cur_state = '0;
		end
	end

	// force from the running peak: clamp at ceiling and floor, then (peak - floor) * scale / 65536, rounded and saturated
	logic [SPEED_W-1:0]         peak_upd;
	logic [SPEED_W-1:0]         peak_diff;
	logic [SPEED_W+SCALE_W-1:0] prod;
	logic [SPEED_W+SCALE_W:0]   rounded;
	logic [SCALE_W:0]           scaled;
	logic [FORCE_W-1:0]         force_new;

	assign peak_upd  = (speed_s1 > cur_state.peak) ? speed_s1 : cur_state.peak;
	assign peak_diff = peak_upd - speed_floor_q;
	assign prod      = peak_diff * force_scale_q;
	assign rounded   = {1'b0, prod} + (SPEED_W + SCALE_W + 1)'(32768);
	assign scaled    = rounded[SPEED_W+SCALE_W:16];

	always_comb begin
		if (peak_upd >= speed_ceiling_q) begin
			force_new = FORCE_MAX;
		end else if (peak_upd <= speed_floor_q) begin
			force_new = '0;
		end else if (|scaled[SCALE_W:FORCE_W]) begin
			force_new = FORCE_MAX;
		end else begin
			force_new = scaled[FORCE_W-1:0];
		end
	end

	// phase machine
	logic above_up, above_low, press_ev, release_ev;

	assign above_up  = travel_s1 > rel_level_q;
	assign above_low = travel_s1 > prs_level_q;

	always_comb begin
		nxt_state  = cur_state;
		press_ev   = 1'b0;
		release_ev = 1'b0;
		case (cur_state.phase)
			PH_UP: begin
				if (!above_up) nxt_state.phase = PH_UP_CONF;
			end
			PH_UP_CONF: begin
				if (above_up) begin
					nxt_state.phase = PH_UP;
				end else begin
					nxt_state.phase = PH_FALL;
					nxt_state.peak  = speed_s1;
				end
			end
			PH_FALL: begin
				if (above_up) begin
					nxt_state.phase = PH_UP;
					nxt_state.peak  = '0;
				end else begin
					nxt_state.peak = peak_upd;
					if (!above_low) nxt_state.phase = PH_FALL_CONF;
				end
			end
			PH_FALL_CONF: begin
				if (above_low) begin
					nxt_state.phase = PH_FALL;
				end else begin
					nxt_state.peak      = peak_upd;
					nxt_state.pressed   = 1'b1;
					nxt_state.force_lvl = force_new;
					nxt_state.phase     = PH_DOWN;
					press_ev            = 1'b1;
				end
			end
			PH_DOWN: begin
				if (above_low) nxt_state.phase = PH_DOWN_CONF;
			end
			PH_DOWN_CONF: begin
				nxt_state.phase = above_low ? PH_RISE : PH_DOWN;
			end
			PH_RISE: begin
				if (above_up) begin
					nxt_state.phase = PH_RISE_CONF;
				end else if (!above_low) begin
					nxt_state.phase = PH_DOWN;
				end
			end
			default: begin
				if (above_up) begin
					nxt_state.pressed = 1'b0;
					nxt_state.phase   = PH_UP;
					release_ev        = 1'b1;
				end else begin
					nxt_state.phase = PH_RISE;
				end
			end
		endcase
	end

	// result register
	logic [M_TDATA_W-1:0] out_data_q;
	logic [M_TDATA_W-1:0] result;

	always_comb begin
		result = '0;
		result[KEY_W-1:0] = key_s1;
		if (range_s1) begin
			result[KEY_W +: PHASE_W]       = nxt_state.phase;
			result[KEY_W+PHASE_W]          = nxt_state.pressed;
			result[KEY_W+PHASE_W+1]        = press_ev;
			result[KEY_W+PHASE_W+2]        = release_ev;
			result[KEY_W+PHASE_W+3 +: FORCE_W] = nxt_state.force_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- hw/rtl/akpvt_checker.sv -----
// port-level checks for the analog key press velocity tracker, with bind
// depends on akpvt_pkg
`timescale 1ns / 1ps

module akpvt_checker
	import akpvt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	// press and release never in one result
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
		else $error("press and release in one transaction");

	// a press lands in down with the pressed bit set
	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[7] && m_tdata[6:4] == PH_DOWN)
		else $error("press event without down phase and pressed bit");

	// a release lands in up with the pressed bit clear
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> !m_tdata[7] && m_tdata[6:4] == PH_UP)
		else $error("release event without up phase and clear pressed bit");

endmodule

bind analog_key_press_velocity_tracker akpvt_checker u_akpvt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/analog_key_press_velocity_tracker_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for analog_key_press_velocity_tracker: directed key strokes,
// then random strokes and noise under several line and force settings with random stalls
// depends on akpvt_pkg and the tracker rtl

module analog_key_press_velocity_tracker_tb;
	import akpvt_pkg::*;

	localparam int KEYS              = 16;
	localparam int ITEMS_PER_SETTING = 250;
	localparam int N_SETTINGS        = 6;
	localparam int N_DIRECTED        = 26;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_FORCE_SCALE + 1'b1;

	// one result transaction, lowest field in the lowest bits
	typedef struct packed {
		logic [FORCE_W-1:0] force_lvl;
		logic               release_event;
		logic               press_event;
		logic               pressed;
		logic [PHASE_W-1:0] phase;
		logic [KEY_W-1:0]   key_number;
	} key_report_t;

	typedef struct {
		logic [TRAVEL_W-1:0] upper;
		logic [TRAVEL_W-1:0] lower;
		logic [SPEED_W-1:0]  floor_spd;
		logic [SPEED_W-1:0]  ceil_spd;
		logic [SCALE_W-1:0]  scale;
	} line_setting_t;

	// per-key phase tracking and force prediction, plus the queue of pending reports
	class key_report_checker;
		logic [TRAVEL_W-1:0] rel_level;
		logic [TRAVEL_W-1:0] prs_level;
		logic [SPEED_W-1:0]  speed_floor;
		logic [SPEED_W-1:0]  speed_ceiling;
		logic [SCALE_W-1:0]  force_scale;
		logic [PHASE_W-1:0]  key_phase [KEYS];
		logic [SPEED_W-1:0]  peak_speed [KEYS];
		logic                pressed_bits [KEYS];
		logic [FORCE_W-1:0]  latched_force [KEYS];
		key_report_t         expected_reports [$];
		int                  mismatches;

		function new();
			rel_level     = REL_LEVEL_RST;
			prs_level     = PRS_LEVEL_RST;
			speed_floor   = SPEED_FLOOR_RST;
			speed_ceiling = SPEED_CEILING_RST;
			force_scale   = FORCE_SCALE_RST;
			for (int k = 0; k < KEYS; k++) begin
				key_phase[k]     = PH_UP;
				peak_speed[k]    = '0;
				pressed_bits[k]  = 1'b0;
				latched_force[k] = '0;
			end
			mismatches = 0;
		endfunction

		function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_REL_LEVEL:     rel_level     = val[TRAVEL_W-1:0];
				CFG_PRS_LEVEL:     prs_level     = val[TRAVEL_W-1:0];
				CFG_SPEED_FLOOR:   speed_floor   = val[SPEED_W-1:0];
				CFG_SPEED_CEILING: speed_ceiling = val[SPEED_W-1:0];
				CFG_FORCE_SCALE:   force_scale   = val[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		// ceiling test first, then floor, then scaled with round half up and clamp
		function logic [FORCE_W-1:0] force_from_peak(logic [SPEED_W-1:0] peak);
			longint unsigned diff;
			longint unsigned scaled;
			if (peak >= speed_ceiling) return FORCE_MAX;
			if (peak <= speed_floor) return '0;
			diff = peak - speed_floor;
			scaled = (diff * force_scale + 64'd32768) >> 16;
			return (scaled > 255) ? FORCE_MAX : scaled[FORCE_W-1:0];
		endfunction

		function void note_sample(logic [KEY_W-1:0] k, logic [TRAVEL_W-1:0] t,
				logic [SPEED_W-1:0] s);
			logic [PHASE_W-1:0] ph;
			logic               above_up;
			logic               above_low;
			key_report_t        rep;
			ph        = key_phase[k];
			above_up  = t > rel_level;
			above_low = t > prs_level;
			rep       = '0;
			rep.key_number = k;
			case (ph)
				PH_UP: if (!above_up) ph = PH_UP_CONF;
				PH_UP_CONF: if (above_up) begin
					ph = PH_UP;
				end else begin
					ph = PH_FALL;
					peak_speed[k] = s;
				end
				PH_FALL: if (above_up) begin
					ph = PH_UP;
					peak_speed[k] = '0;
				end else begin
					if (s > peak_speed[k]) peak_speed[k] = s;
					if (!above_low) ph = PH_FALL_CONF;
				end
				PH_FALL_CONF: if (above_low) begin
					ph = PH_FALL;
				end else begin
					if (s > peak_speed[k]) peak_speed[k] = s;
					pressed_bits[k]  = 1'b1;
					latched_force[k] = force_from_peak(peak_speed[k]);
					rep.press_event  = 1'b1;
					ph = PH_DOWN;
				end
				PH_DOWN: if (above_low) ph = PH_DOWN_CONF;
				PH_DOWN_CONF: ph = above_low ? PH_RISE : PH_DOWN;
				PH_RISE: if (above_up) begin
					ph = PH_RISE_CONF;
				end else if (!above_low) begin
					ph = PH_DOWN;
				end
				default: if (above_up) begin
					pressed_bits[k]   = 1'b0;
					rep.release_event = 1'b1;
					ph = PH_UP;
				end else begin
					ph = PH_RISE;
				end
			endcase
			key_phase[k]  = ph;
			rep.phase     = ph;
			rep.pressed   = pressed_bits[k];
			rep.force_lvl = latched_force[k];
			expected_reports.push_back(rep);
		endfunction

		function void flag(string what, int unsigned want, int unsigned got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_report(logic [M_TDATA_W-1:0] tdata);
			key_report_t got;
			key_report_t want;
			got = tdata[$bits(key_report_t)-1:0];
			if (expected_reports.size() == 0) begin
				flag("unexpected report, key_number", 0, got.key_number);
				return;
			end
			want = expected_reports.pop_front();
			if (got.key_number !== want.key_number)
				flag("key_number", want.key_number, got.key_number);
			if (got.phase !== want.phase) flag("phase", want.phase, got.phase);
			if (got.pressed !== want.pressed) flag("pressed", want.pressed, got.pressed);
			if (got.press_event !== want.press_event)
				flag("press_event", want.press_event, got.press_event);
			if (got.release_event !== want.release_event)
				flag("release_event", want.release_event, got.release_event);
			if (got.force_lvl !== want.force_lvl)
				flag("force_res", want.force_lvl, got.force_lvl);
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	key_report_checker report_chk = new();
	int unsigned       send_idle_pct = 38;
	int unsigned       recv_idle_pct = 76;
	int unsigned       samples_sent  = 0;

	analog_key_press_velocity_tracker #(
		.KEY_COUNT(KEYS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: check each transaction, then pick the next ready at random
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) report_chk.check_report(m_tdata);
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// one sample transaction, with random idle cycles ahead of it
	task automatic send_sample(input logic [KEY_W-1:0] k, input logic [TRAVEL_W-1:0] t,
			input logic [SPEED_W-1:0] s);
		send_idle_pct = (samples_sent < 500) ? 38 : (samples_sent < 1000) ? 76 : 0;
		recv_idle_pct = (samples_sent < 500) ? 76 : (samples_sent < 1000) ? 38 : 0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-KEY_W-TRAVEL_W-SPEED_W){1'b0}}, s, t, k};
		do @(posedge clk); while (!s_tready);
		report_chk.note_sample(k, t, s);
		samples_sent++;
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		report_chk.note_write(idx, val);
	endtask

	// write all registers; extras adds junk above each travel and speed register's width and stray indexes
	task automatic apply_setting(input line_setting_t st, input bit extras);
		logic [CFG_DATA_W-1:0] junk;
		junk = extras ? CFG_DATA_W'($urandom) : '0;
		if (extras) begin
			for (int i = CFG_UNUSED_FIRST; i < (1 << CFG_IDX_W); i++)
				cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		end
		cfg_write(CFG_REL_LEVEL, {junk[CFG_DATA_W-1:TRAVEL_W], st.upper});
		cfg_write(CFG_PRS_LEVEL, {junk[CFG_DATA_W-1:TRAVEL_W], st.lower});
		cfg_write(CFG_SPEED_FLOOR, {junk[CFG_DATA_W-1:SPEED_W], st.floor_spd});
		cfg_write(CFG_SPEED_CEILING, {junk[CFG_DATA_W-1:SPEED_W], st.ceil_spd});
		cfg_write(CFG_FORCE_SCALE, st.scale);
		cfg_we <= 1'b0;
	endtask

	// hand-picked strokes at reset settings: line boundaries, every phase move, bounces
	int directed [N_DIRECTED][3] = '{
		'{0, 3277, 5},   '{0, 3278, 0},   '{0, 3000, 10},  '{0, 2000, 1000},
		'{0, 4096, 0},   '{0, 0, 0},      '{0, 1000, 300}, '{0, 819, 65535},
		'{0, 820, 0},    '{0, 500, 0},    '{0, 0, 0},      '{0, 820, 0},
		'{0, 0, 0},      '{0, 820, 0},    '{0, 3277, 0},   '{0, 819, 0},
		'{0, 900, 0},    '{0, 3278, 0},   '{0, 8191, 0},   '{0, 3277, 0},
		'{0, 4096, 0},   '{0, 4096, 0},   '{15, 0, 0},     '{15, 0, 40000},
		'{15, 0, 0},     '{15, 0, 0}
	};

	// main sequence
	initial begin
		line_setting_t       settings [N_SETTINGS];
		int                  pos [KEYS];
		bit                  falling [KEYS];
		int                  delta;
		int unsigned         roll;
		logic [KEY_W-1:0]    k;
		logic [TRAVEL_W-1:0] t;
		logic [SPEED_W-1:0]  s;

		settings[0] = '{REL_LEVEL_RST, PRS_LEVEL_RST, SPEED_FLOOR_RST, SPEED_CEILING_RST,
			FORCE_SCALE_RST};
		settings[1] = '{13'd4096, 13'd0, 16'd1000, 16'd9000, 24'd2089};
		settings[2] = '{13'd0, 13'd0, 16'hFFFF, 16'd0, 24'hFFFFFF};
		settings[3] = '{13'd4096, 13'd4096, 16'd0, 16'hFFFF, 24'd0};
		settings[4].upper     = TRAVEL_W'($urandom_range(0, 4096));
		settings[4].lower     = TRAVEL_W'($urandom_range(0, settings[4].upper));
		settings[4].floor_spd = SPEED_W'($urandom_range(0, 60000));
		settings[4].ceil_spd  = SPEED_W'($urandom_range(settings[4].floor_spd + 1, 65535));
		settings[4].scale     = SCALE_W'((255 * 65536)
			/ (settings[4].ceil_spd - settings[4].floor_spd) + $urandom_range(0, 3));
		settings[5] = '{13'd2048, 13'd1024, 16'd30000, 16'd30000, 24'hFFFFFF};
		for (int i = 0; i < KEYS; i++) begin
			pos[i]     = 4096;
			falling[i] = 1'b1;
		end
		k = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_sample(KEY_W'(directed[i][0]), TRAVEL_W'(directed[i][1]),
				SPEED_W'(directed[i][2]));

		for (int p = 0; p < N_SETTINGS; p++) begin
			// block must be idle before a register write
			s_tvalid <= 1'b0;
			while (report_chk.expected_reports.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			apply_setting(settings[p], (p == 0) || (p == 4));

			// mostly full strokes per key, some small reverse bounces and raw noise
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				if ($urandom_range(0, 1)) k = KEY_W'($urandom_range(0, KEYS - 1));
				roll = $urandom_range(0, 99);
				if (roll < 12) begin
					t = TRAVEL_W'($urandom_range(0, 8191));
				end else begin
					delta = $urandom_range(0, 1400);
					if (falling[k]) delta = -delta;
					if (roll < 22) delta = -delta / 4;
					pos[k] += delta;
					if (pos[k] <= 0) begin
						pos[k] = 0;
						if ($urandom_range(0, 1)) falling[k] = 1'b0;
					end else if (pos[k] >= 4096) begin
						pos[k] = 4096;
						if ($urandom_range(0, 1)) falling[k] = 1'b1;
					end
					t = TRAVEL_W'(pos[k]);
				end
				roll = $urandom_range(0, 99);
				if (roll < 15) s = '0;
				else if (roll < 25) s = 16'hFFFF;
				else if (roll < 60) s = SPEED_W'($urandom_range(0, 12000));
				else s = SPEED_W'($urandom_range(0, 65535));
				send_sample(k, t, s);
			end
		end

		s_tvalid <= 1'b0;
		while (report_chk.expected_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (report_chk.mismatches == 0) begin
			$display("analog_key_press_velocity_tracker_tb: PASS");
		end else begin
			$display("analog_key_press_velocity_tracker_tb: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("analog_key_press_velocity_tracker_tb: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/akpvt_pkg.sv
hw/rtl/akpvt_ram.sv
hw/rtl/analog_key_press_velocity_tracker.sv
hw/rtl/akpvt_checker.sv
tb/analog_key_press_velocity_tracker_tb.sv
